/* rtl/core/mat_pkg.sv */
// Shared types, constants and codes for the moving-average thermostat.
package mat_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 128;
    localparam int SAMPLE_W             = 10;
    localparam int SETPOINT_W           = 8;
    localparam int CFG_INDEX_W          = 2;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [SETPOINT_W-1:0] SETPOINT_LOW_RESET  = 8'd88;
    localparam logic [SETPOINT_W-1:0] SETPOINT_HIGH_RESET = 8'd90;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_HIGH = 2'd1;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_UPDATE,
        BACK_DIVIDE,
        BACK_DELIVER
    } back_state_t;

    // Head of the request queue as seen by the back part
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } front_item_t;

    typedef struct packed {
        logic [SETPOINT_W-1:0] setpoint_low;
        logic [SETPOINT_W-1:0] setpoint_high;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_temp;
        logic                window_full;
        logic                heater_on;
        logic                out_of_band;
    } result_t;

endpackage

/* rtl/core/moving_average_thermostat_core.sv */
// Top level of the moving-average hysteresis thermostat core.
// Each accepted request carries one 10-bit sample in quarter degrees. The core
// stores it in a ring of WINDOW_DEPTH samples, updates a running total and
// fill count, and returns one result: the truncated mean of the filled
// entries, a window-full flag, the heater state and an out-of-band flag.
// Until the ring is full the heater stays off. After that it turns on when
// the mean is below setpoint_low and off when it is above setpoint_high;
// the low test is made first. The mean comes from a serial divider, which
// produces one quotient bit per cycle, after the slot to be replaced is read
// from the ring memory. A two-entry request queue takes new samples while
// the back part works and a finished result waits in the output register.
// Setpoints are written through cfg_write_en / cfg_index / cfg_data; the
// user must do so only while the core is idle, which it does not enforce;
// indexes other than 0 and 1 are ignored. No clearing pass after reset.
module moving_average_thermostat_core #(
    parameter int WINDOW_DEPTH = mat_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mat_pkg::SETPOINT_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mat_pkg::SAMPLE_W-1:0]   adc_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mat_pkg::SAMPLE_W-1:0]   average_temp,
    output logic                           window_full,
    output logic                           heater_on,
    output logic                           out_of_band
);
    import mat_pkg::*;

    logic [SETPOINT_W-1:0] setpoint_low_reg;
    logic [SETPOINT_W-1:0] setpoint_high_reg;
    cfg_t                  cfg;
    front_item_t           item;
    logic                  pop;
    result_t               result;

    // Setpoint registers; hold their value unless written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_low_reg  <= SETPOINT_LOW_RESET;
            setpoint_high_reg <= SETPOINT_HIGH_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_SETPOINT_LOW:  setpoint_low_reg  <= cfg_data;
                CFG_SETPOINT_HIGH: setpoint_high_reg <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign cfg.setpoint_low  = setpoint_low_reg;
    assign cfg.setpoint_high = setpoint_high_reg;

    // Front: queue incoming sample requests
    mat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .pop        (pop),
        .item       (item)
    );

    // Back: ring update, mean, hysteresis and the output register
    mat_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .pop       (pop),
        .cfg       (cfg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign average_temp = result.average_temp;
    assign window_full  = result.window_full;
    assign heater_on    = result.heater_on;
    assign out_of_band  = result.out_of_band;

endmodule

/* rtl/core/mat_front.sv */
// Front part: accepts sample requests into a short queue for the back part.
module mat_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mat_pkg::SAMPLE_W-1:0]  adc_sample,
    input  logic                          pop,
    output mat_pkg::front_item_t          item
);
    import mat_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SAMPLE_W-1:0] queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                push;
    logic                pop_ok;

    assign in_stall    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push        = in_valid && !in_stall;
    assign pop_ok      = pop && (count_reg != '0);
    assign item.valid  = (count_reg != '0);
    assign item.sample = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the accepted sample
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= adc_sample;
        end
    end

endmodule

/* rtl/core/mat_divider.sv */
// Restoring serial divider: one quotient bit per cycle.
module mat_divider #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int ITER_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out and the quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

endmodule

/* rtl/core/mat_back.sv */
// Back part: sample ring, running total, mean, hysteresis and result register.
module mat_back #(
    parameter int WINDOW_DEPTH = mat_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mat_pkg::front_item_t item,
    output logic                 pop,
    input  mat_pkg::cfg_t        cfg,
    input  logic                 out_stall,
    output logic                 out_valid,
    output mat_pkg::result_t     result
);
    import mat_pkg::*;

    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int TOTAL_W = $clog2(((1 << SAMPLE_W) - 1) * WINDOW_DEPTH + 1);

    back_state_t          state_reg, state_next;
    logic [SAMPLE_W-1:0]  sample_ring_reg [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]  rd_data_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [PTR_W-1:0]     wptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 heater_reg, heater_next;
    logic                 out_valid_reg;
    result_t              result_reg, result_next;
    logic                 div_start;
    logic                 div_done;
    logic [TOTAL_W-1:0]   quotient;
    logic                 load_out;
    logic                 ring_full;
    logic [SAMPLE_W-1:0]  mean;
    logic                 below;
    logic                 above;

    assign ring_full = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign mean      = quotient[SAMPLE_W-1:0];
    assign below     = (mean < SAMPLE_W'(cfg.setpoint_low));
    assign above     = (mean > SAMPLE_W'(cfg.setpoint_high));
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Drop the oldest sample once the ring is full, then add the new one
    assign total_next = total_reg - (ring_full ? TOTAL_W'(rd_data_reg) : '0)
                        + TOTAL_W'(sample_reg);
    assign count_next = ring_full ? count_reg : count_reg + 1'b1;

    mat_divider #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        heater_next = heater_reg;
        result_next = result_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (item.valid)
                begin
                    pop        = 1'b1;
                    state_next = BACK_UPDATE;
                end
            end
            BACK_UPDATE:
            begin
                div_start  = 1'b1;
                state_next = BACK_DIVIDE;
            end
            BACK_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = BACK_DELIVER;
                end
            end
            BACK_DELIVER:
            begin
                result_next.out_of_band = 1'b0;
                if (ring_full && below)
                begin
                    heater_next             = 1'b1;
                    result_next.out_of_band = 1'b1;
                end
                else if (ring_full && above)
                begin
                    heater_next             = 1'b0;
                    result_next.out_of_band = 1'b1;
                end
                result_next.average_temp = mean;
                result_next.window_full  = ring_full;
                result_next.heater_on    = heater_next;
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            wptr_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            heater_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
            begin
                wptr_reg  <= (wptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                count_reg <= count_next;
                total_reg <= total_next;
            end
            if (load_out)
            begin
                heater_reg    <= heater_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg <= item.sample;
        end
        if (load_out)
        begin
            result_reg <= result_next;
        end
    end

    // Ring memory: read the slot to be replaced, then overwrite it
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= sample_ring_reg[wptr_reg];
        end
        if (div_start)
        begin
            sample_ring_reg[wptr_reg] <= sample_reg;
        end
    end

endmodule

/* rtl/core/mat_checker.sv */
// Port-level checks for the thermostat core and the bind that attaches them.
module mat_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [mat_pkg::SAMPLE_W-1:0] average_temp,
    input logic                         window_full,
    input logic                         heater_on,
    input logic                         out_of_band
);
    import mat_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(average_temp)
            && $stable(window_full) && $stable(heater_on) && $stable(out_of_band))
        else $error("stalled result changed");

    // Before the window fills, out_of_band stays low
    a_no_oob_filling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_full |-> !out_of_band)
        else $error("out_of_band set before window full");

    // The heater stays off until the window first fills
    a_heater_off_filling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_full |-> !heater_on)
        else $error("heater on before window full");

    // Turning on needs a mean below an 8-bit setpoint
    a_on_below_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_band && heater_on |-> average_temp[SAMPLE_W-1:SETPOINT_W] == '0)
        else $error("heater turned on with mean above any setpoint");

endmodule

bind moving_average_thermostat_core mat_checker u_mat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average_temp (average_temp),
    .window_full  (window_full),
    .heater_on    (heater_on),
    .out_of_band  (out_of_band)
);
